>>> rtl/core/assert_macros.svh
// Assertion macros shared by the vector normalizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define VN_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("vector normalizer: property violated");
`define VN_NEVER(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("vector normalizer: forbidden condition seen");
`else
`define VN_ASSERT(name, prop)
`define VN_NEVER(name, expr)
`endif
`endif

>>> rtl/core/vn_pkg.sv
// Shared widths, constants and types of the vector normalizer.
package vn_pkg;

   localparam int COMP_W      = 32;
   localparam int SQ_W        = 64;
   localparam int MAG_W       = 33;
   localparam int UNIT_W      = 32;
   localparam int UNIT_FRAC   = 30;
   localparam int QUOT_BITS   = 31;
   localparam int SQRT_STAGES = 32;
   localparam int FRONT_STAGES = 3;
   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int REQ_TDATA_W = 96;
   localparam int RSP_TDATA_W = 136;

   typedef struct packed {
      logic [2:0][COMP_W-1:0] mag_abs;
      logic [2:0]             neg;
      logic                   zero;
   } pay_type;

   typedef struct packed {
      logic [SQ_W-1:0] sum;
      pay_type         pay;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
   } qstat_type;

endpackage

>>> rtl/core/vn_front.sv
// Front end: takes vectors, forms magnitudes and signs, squares and sums them.
module vn_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [vn_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  vn_pkg::qstat_type              qstat,
   output vn_pkg::push_type               push
);

   logic                              v1_ff, v2_ff, v3_ff;
   logic [2:0][vn_pkg::COMP_W-1:0]    abs1_ff, abs2_ff, abs3_ff;
   logic [2:0]                        neg1_ff, neg2_ff, neg3_ff;
   logic                              zero1_ff, zero2_ff, zero3_ff;
   logic [2:0][vn_pkg::SQ_W-1:0]      sq2_ff;
   logic [vn_pkg::SQ_W-1:0]           sum3_ff;
   logic [2:0][vn_pkg::COMP_W-1:0]    abs1_in;
   logic [2:0]                        neg1_in;
   logic [2:0][vn_pkg::SQ_W-1:0]      sq2_in;
   logic [vn_pkg::SQ_W-1:0]           sum3_in;
   logic [vn_pkg::CNT_W:0]            booked;
   logic                              accept;

   // Items still in the front stages hold a reserved queue slot.
   assign booked = {1'b0, qstat.count} + (vn_pkg::CNT_W+1)'(v1_ff)
                 + (vn_pkg::CNT_W+1)'(v2_ff) + (vn_pkg::CNT_W+1)'(v3_ff);
   assign req_tready = booked < (vn_pkg::CNT_W+1)'(vn_pkg::QUEUE_DEPTH);
   assign accept = req_tvalid && req_tready;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = req_tdata[i*vn_pkg::COMP_W + vn_pkg::COMP_W-1];
         abs1_in[i] = neg1_in[i] ? (~req_tdata[i*vn_pkg::COMP_W +: vn_pkg::COMP_W] + 1'b1)
                                 : req_tdata[i*vn_pkg::COMP_W +: vn_pkg::COMP_W];
         sq2_in[i]  = vn_pkg::SQ_W'(abs1_ff[i]) * vn_pkg::SQ_W'(abs1_ff[i]);
      end
      sum3_in = sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      abs1_ff  <= abs1_in;
      neg1_ff  <= neg1_in;
      zero1_ff <= (req_tdata == '0);
      sq2_ff   <= sq2_in;
      abs2_ff  <= abs1_ff;
      neg2_ff  <= neg1_ff;
      zero2_ff <= zero1_ff;
      sum3_ff  <= sum3_in;
      abs3_ff  <= abs2_ff;
      neg3_ff  <= neg2_ff;
      zero3_ff <= zero2_ff;
   end

   assign push.valid            = v3_ff;
   assign push.item.sum         = sum3_ff;
   assign push.item.pay.mag_abs = abs3_ff;
   assign push.item.pay.neg     = neg3_ff;
   assign push.item.pay.zero    = zero3_ff;

endmodule

>>> rtl/core/vn_queue.sv
// Short queue between the front end and the root and divide back end.
`include "assert_macros.svh"
module vn_queue (
   input  logic               clock,
   input  logic               reset,
   input  vn_pkg::push_type   push,
   input  logic               pop,
   output logic               head_valid,
   output vn_pkg::item_type   head,
   output vn_pkg::qstat_type  qstat
);

   vn_pkg::item_type              mem_ff [vn_pkg::QUEUE_DEPTH];
   logic [vn_pkg::PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [vn_pkg::CNT_W-1:0]      count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + vn_pkg::CNT_W'(push.valid) - vn_pkg::CNT_W'(pop);
      end
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

   assign head_valid  = (count_ff != '0);
   assign head        = mem_ff[rd_ptr_ff];
   assign qstat.count = count_ff;

   `VN_NEVER(q_overflow, push.valid && !pop && count_ff == vn_pkg::CNT_W'(vn_pkg::QUEUE_DEPTH))
   `VN_NEVER(q_underflow, pop && count_ff == '0)
   `VN_ASSERT(q_count_moves, push.valid && !pop |=> count_ff == $past(count_ff) + 1'b1)

endmodule

>>> rtl/core/vn_back.sv
// Back end: pipelined square root, three pipelined dividers and the output register.
`include "assert_macros.svh"
module vn_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           head_valid,
   input  vn_pkg::item_type               head,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [vn_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser
);

   localparam int NS = vn_pkg::SQRT_STAGES;
   localparam int ND = vn_pkg::QUOT_BITS;

   logic                         en;
   logic                         sv_ff  [NS];
   logic [vn_pkg::SQ_W-1:0]      sn_ff  [NS];
   logic [vn_pkg::SQ_W-1:0]      sr_ff  [NS];
   vn_pkg::pay_type              sp_ff  [NS];
   logic                         dv_ff  [ND];
   logic [2:0][vn_pkg::SQ_W-1:0] drem_ff [ND];
   logic [2:0][ND-1:0]           dq_ff  [ND];
   logic [vn_pkg::MAG_W-1:0]     dmag_ff [ND];
   logic [2:0]                   dneg_ff [ND];
   logic                         dzero_ff [ND];
   logic                         rsp_valid_ff;
   logic [2:0][vn_pkg::UNIT_W-1:0] unit_ff;
   logic [2:0][vn_pkg::UNIT_W-1:0] unit_in;
   logic [vn_pkg::MAG_W-1:0]     len_ff;
   logic                         zero_ff;

   // The whole back end advances together unless a result is stuck at the output.
   assign en  = !rsp_valid_ff || rsp_tready;
   assign pop = en && head_valid;

   for (genvar k = 0; k < NS; k++) begin : g_sqrt
      logic                    v_i;
      logic [vn_pkg::SQ_W-1:0] n_i, r_i, bit_c, trial;
      vn_pkg::pay_type         p_i;
      if (k == 0) begin : g_first
         assign v_i = head_valid;
         assign n_i = head.sum;
         assign r_i = '0;
         assign p_i = head.pay;
      end else begin : g_next
         assign v_i = sv_ff[k-1];
         assign n_i = sn_ff[k-1];
         assign r_i = sr_ff[k-1];
         assign p_i = sp_ff[k-1];
      end
      assign bit_c = vn_pkg::SQ_W'(1) << (vn_pkg::SQ_W - 2 - 2*k);
      assign trial = r_i + bit_c;
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k] <= 1'b0;
         end else if (en) begin
            sv_ff[k] <= v_i;
         end
         if (en) begin
            sp_ff[k] <= p_i;
            if (n_i >= trial) begin
               sn_ff[k] <= n_i - trial;
               sr_ff[k] <= (r_i >> 1) + bit_c;
            end else begin
               sn_ff[k] <= n_i;
               sr_ff[k] <= r_i >> 1;
            end
         end
      end
   end

   for (genvar d = 0; d < ND; d++) begin : g_div
      logic                         v_i, z_i;
      logic [2:0][vn_pkg::SQ_W-1:0] rem_i;
      logic [2:0][ND-1:0]           q_i;
      logic [vn_pkg::MAG_W-1:0]     mag_i;
      logic [2:0]                   neg_i;
      logic [vn_pkg::SQ_W-1:0]      dvs;
      if (d == 0) begin : g_first
         assign v_i   = sv_ff[NS-1];
         assign z_i   = sp_ff[NS-1].zero;
         assign mag_i = sr_ff[NS-1][vn_pkg::MAG_W-1:0];
         assign neg_i = sp_ff[NS-1].neg;
         assign q_i   = '0;
         for (genvar c = 0; c < 3; c++) begin : g_init
            assign rem_i[c] = vn_pkg::SQ_W'(sp_ff[NS-1].mag_abs[c]) << vn_pkg::UNIT_FRAC;
         end
      end else begin : g_next
         assign v_i   = dv_ff[d-1];
         assign z_i   = dzero_ff[d-1];
         assign mag_i = dmag_ff[d-1];
         assign neg_i = dneg_ff[d-1];
         assign q_i   = dq_ff[d-1];
         assign rem_i = drem_ff[d-1];
      end
      assign dvs = vn_pkg::SQ_W'(mag_i) << (ND - 1 - d);
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[d] <= 1'b0;
         end else if (en) begin
            dv_ff[d] <= v_i;
         end
         if (en) begin
            dzero_ff[d] <= z_i;
            dmag_ff[d]  <= mag_i;
            dneg_ff[d]  <= neg_i;
            for (int c = 0; c < 3; c++) begin
               if (rem_i[c] >= dvs) begin
                  drem_ff[d][c]         <= rem_i[c] - dvs;
                  dq_ff[d][c]           <= q_i[c] | (ND'(1) << (ND - 1 - d));
               end else begin
                  drem_ff[d][c]         <= rem_i[c];
                  dq_ff[d][c]           <= q_i[c];
               end
            end
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (dzero_ff[ND-1]) begin
            unit_in[c] = '0;
         end else if (dneg_ff[ND-1][c]) begin
            unit_in[c] = ~vn_pkg::UNIT_W'(dq_ff[ND-1][c]) + 1'b1;
         end else begin
            unit_in[c] = vn_pkg::UNIT_W'(dq_ff[ND-1][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_ff[ND-1];
      end
      if (en) begin
         unit_ff <= unit_in;
         len_ff  <= dmag_ff[ND-1];
         zero_ff <= dzero_ff[ND-1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = zero_ff;
   assign rsp_tdata  = {(vn_pkg::RSP_TDATA_W - 3*vn_pkg::UNIT_W - vn_pkg::MAG_W)'(0),
                        len_ff, unit_ff[2], unit_ff[1], unit_ff[0]};

   `VN_ASSERT(zero_gives_zero_len, rsp_valid_ff && zero_ff |-> len_ff == '0)
   `VN_ASSERT(stall_holds_len, $past(rsp_valid_ff && !rsp_tready) |-> $stable(len_ff))

endmodule

>>> rtl/core/vector3_normalizer.sv
// Top level of the three-component fixed-point vector normalizer.
//
//   channel   direction  handshake            payload
//   req       in         req_tvalid/tready    tdata: x_in, y_in, z_in (Q16.16)
//   rsp       out        rsp_tvalid/tready    tdata: x/y/z_unit (Q1.30), length; tuser: is_zero
//
// One vector is accepted per cycle while req_tready is high; each passes through three front
// stages, one queue slot, 32 square-root stages, 31 divider stages and the output register.
// The root and divider pipelines are fully unrolled, one result bit per stage.
// Reset is synchronous and clears all valid flags and the queue; no clearing pass follows.
// A stalled output freezes the back end; the queue lets the front end keep accepting until all slots are booked.
module vector3_normalizer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // x_in [31:0], y_in [63:32], z_in [95:64]
   input  logic [vn_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // x_unit [31:0], y_unit [63:32], z_unit [95:64], length [128:96], zero pad above
   output logic [vn_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // is_zero [0]
   output logic                           rsp_tuser
);

   vn_pkg::push_type  push;
   vn_pkg::qstat_type qstat;
   vn_pkg::item_type  head;
   logic              head_valid;
   logic              pop;

   vn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .qstat      (qstat),
      .push       (push)
   );

   vn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head),
      .qstat      (qstat)
   );

   vn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
